// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/xst_pkg.sv
// ----------------------------------------------------------------------------
// xst_pkg
// Types, constants and character classes of the XML stream tokenizer.
// ----------------------------------------------------------------------------
package xst_pkg;

  localparam int unsigned DefTagDepth  = 16;
  localparam int unsigned DefNameStore = 512;
  localparam int unsigned CpW          = 21;
  localparam int unsigned NestW        = 5;

  typedef enum logic [2:0] {
    EV_ENAME     = 3'd0,
    EV_START_END = 3'd1,
    EV_ELEM_END  = 3'd2,
    EV_ANAME     = 3'd3,
    EV_AVAL      = 3'd4,
    EV_AVAL_END  = 3'd5,
    EV_TEXT      = 3'd6
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SYNTAX   = 2'd1,
    ERR_MISMATCH = 2'd2,
    ERR_CAPACITY = 2'd3
  } error_code_e;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       event_kind;
    logic [CpW-1:0]   event_char;
    logic [NestW-1:0] nest_depth;
    logic [1:0]       error_code;
  } out_item_t;

  localparam logic [CpW-1:0] ChLt    = 21'h3C;
  localparam logic [CpW-1:0] ChGt    = 21'h3E;
  localparam logic [CpW-1:0] ChSlash = 21'h2F;
  localparam logic [CpW-1:0] ChQmark = 21'h3F;
  localparam logic [CpW-1:0] ChEq    = 21'h3D;
  localparam logic [CpW-1:0] ChApos  = 21'h27;
  localparam logic [CpW-1:0] ChQuot  = 21'h22;

  function automatic logic in_rng(input logic [CpW-1:0] u, input int unsigned lo,
                                  input int unsigned hi);
    return (u >= CpW'(lo)) && (u <= CpW'(hi));
  endfunction

  function automatic logic is_white(input logic [CpW-1:0] u);
    return (u == 21'h20) || (u == 21'h09) || (u == 21'h0D) || (u == 21'h0A);
  endfunction

  function automatic logic is_name_start(input logic [CpW-1:0] u);
    return in_rng(u, 'h61, 'h7A) || (u == 21'h3A) || (u == 21'h5F) ||
           in_rng(u, 'h41, 'h5A) || in_rng(u, 'hC0, 'hD6) ||
           in_rng(u, 'hD8, 'hF6) || in_rng(u, 'hF8, 'h2FF) ||
           in_rng(u, 'h370, 'h37D) || in_rng(u, 'h37F, 'h1FFF) ||
           in_rng(u, 'h200C, 'h200D) || in_rng(u, 'h2070, 'h218F) ||
           in_rng(u, 'h2C00, 'h2FEF) || in_rng(u, 'h3001, 'hD7FF) ||
           in_rng(u, 'hF900, 'hFDCF) || in_rng(u, 'hFDF0, 'hFFFD) ||
           in_rng(u, 'h10000, 'hEFFFF);
  endfunction

  function automatic logic is_name_part(input logic [CpW-1:0] u);
    return is_name_start(u) || (u == 21'h2D) || (u == 21'h2E) ||
           in_rng(u, 'h30, 'h39) || in_rng(u, 'h300, 'h36F) ||
           in_rng(u, 'h203F, 'h2040);
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "v";
      3'd1: r = "e";
      3'd2: r = "r";
      3'd3: r = "s";
      3'd4: r = "i";
      3'd5: r = "o";
      default: r = "n";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] one_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = "1";
      2'd1: r = ".";
      default: r = "0";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] encoding_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "e";
      3'd1: r = "n";
      3'd2: r = "c";
      3'd3: r = "o";
      3'd4: r = "d";
      3'd5: r = "i";
      3'd6: r = "n";
      default: r = "g";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] utf8_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = "u";
      3'd1: r = "t";
      3'd2: r = "f";
      3'd3: r = "-";
      default: r = "8";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xml_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = "x";
      2'd1: r = "m";
      default: r = "l";
    endcase
    return r;
  endfunction

endpackage

// File: rtl/xst_store.sv
// ----------------------------------------------------------------------------
// xst_store
// Name character memory and element start memory, each with one write port
// and one registered read port, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module xst_store #(
  parameter int unsigned TAG_DEPTH  = xst_pkg::DefTagDepth,
  parameter int unsigned NAME_STORE = xst_pkg::DefNameStore,
  localparam int unsigned NAW = $clog2(NAME_STORE),
  localparam int unsigned FW  = $clog2(NAME_STORE + 1),
  localparam int unsigned TAW = $clog2(TAG_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     name_we_i,
  input  logic [NAW-1:0]           name_waddr_i,
  input  logic [xst_pkg::CpW-1:0]  name_wdata_i,
  input  logic [NAW-1:0]           name_raddr_i,
  output logic [xst_pkg::CpW-1:0]  name_rdata_o,
  input  logic                     start_we_i,
  input  logic [TAW-1:0]           start_waddr_i,
  input  logic [FW-1:0]            start_wdata_i,
  input  logic [TAW-1:0]           start_raddr_i,
  output logic [FW-1:0]            start_rdata_o
);
  import xst_pkg::*;

  logic [CpW-1:0] name_mem [NAME_STORE];
  logic [FW-1:0]  start_mem [TAG_DEPTH];
  logic [CpW-1:0] name_rdata_q;
  logic [FW-1:0]  start_rdata_q;

  always_ff @(posedge clk_i) begin
    if (name_we_i) begin
      name_mem[name_waddr_i] <= name_wdata_i;
    end
    if (name_we_i && (name_waddr_i == name_raddr_i)) begin
      name_rdata_q <= name_wdata_i;
    end else begin
      name_rdata_q <= name_mem[name_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_we_i) begin
      start_mem[start_waddr_i] <= start_wdata_i;
    end
    if (start_we_i && (start_waddr_i == start_raddr_i)) begin
      start_rdata_q <= start_wdata_i;
    end else begin
      start_rdata_q <= start_mem[start_raddr_i];
    end
  end

  assign name_rdata_o  = name_rdata_q;
  assign start_rdata_o = start_rdata_q;

endmodule

// File: rtl/xml_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// xml_stream_tokenizer
// Streaming XML tokenizer over code points with a memory-held name stack.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Word
//  in      | input     | in_valid_i/in_ready_o | in_data_i (code point, restart)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (event)
//  cfg     | input     | cfg_we_i              | cfg_data_i (text_min_depth)
//
// One word is taken per cycle; its event, if any, shows in the next cycle.
// The stack top start and the next compare character are read ahead each
// cycle from registered-read memories, so the end-tag compare adds no stall.
// The input stalls only while an event waits and out_ready_i is low.
// After reset no clearing pass is needed.
`include "assert_macros.svh"

module xml_stream_tokenizer #(
  parameter int unsigned TAG_DEPTH  = xst_pkg::DefTagDepth,
  parameter int unsigned NAME_STORE = xst_pkg::DefNameStore
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xst_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xst_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_data_i
);
  import xst_pkg::*;

  localparam int unsigned NAW = $clog2(NAME_STORE);
  localparam int unsigned FW  = $clog2(NAME_STORE + 1);
  localparam int unsigned TAW = $clog2(TAG_DEPTH);
  localparam int unsigned DPW = $clog2(TAG_DEPTH + 1);
  localparam logic [5:0] NotXml = 6'd63;

  typedef enum logic [4:0] {
    S_TEXT, S_LT, S_ENAME, S_BEFORE_ATTR, S_ANAME, S_AFTER_ANAME, S_BEFORE_VAL,
    S_VAL, S_AFTER_VAL, S_EMPTY_CLOSE, S_END_FIRST, S_END_REST, S_END_CLOSE,
    S_PI_FIRST, S_PI_NAME, S_PI_AFTER, S_DECL, S_PI_SKIP, S_PI_CLOSE
  } state_e;

  typedef enum logic [1:0] {DECL_GO, DECL_ERR, DECL_DONE} decl_code_e;

  typedef struct packed {
    decl_code_e code;
    logic [5:0] step;
    logic       apos;
  } decl_res_t;

  function automatic decl_res_t decl_take(input logic [CpW-1:0] c,
                                          input logic [5:0] s, input logic apos);
    decl_res_t r;
    logic sp;
    logic [CpW-1:0] low;
    logic [CpW-1:0] qc;
    logic [5:0] k;
    sp   = is_white(c);
    low  = in_rng(c, 'h41, 'h5A) ? c + CpW'(32) : c;
    qc   = apos ? ChApos : ChQuot;
    r.code = DECL_ERR;
    r.step = s;
    r.apos = apos;
    k = 6'd0;
    if (s <= 6'd6) begin
      if (c == CpW'(version_char(s[2:0]))) begin r.code = DECL_GO; r.step = s + 6'd1; end
    end else if (s == 6'd7 || s == 6'd22) begin
      if (sp) r.code = DECL_GO;
      else if (c == ChEq) begin r.code = DECL_GO; r.step = s + 6'd1; end
    end else if (s == 6'd8 || s == 6'd23) begin
      if (sp) r.code = DECL_GO;
      else if (c == ChApos || c == ChQuot) begin
        r.code = DECL_GO; r.step = s + 6'd1; r.apos = (c == ChApos);
      end
    end else if (s >= 6'd9 && s <= 6'd11) begin
      k = s - 6'd9;
      if (c == CpW'(one_char(k[1:0]))) begin r.code = DECL_GO; r.step = s + 6'd1; end
    end else if (s == 6'd12 || s == 6'd29) begin
      if (c == qc) begin r.code = DECL_GO; r.step = s + 6'd1; end
    end else if (s == 6'd13) begin
      if (sp) begin r.code = DECL_GO; r.step = 6'd14; end
      else if (c == ChQmark) r.code = DECL_DONE;
    end else if (s == 6'd14) begin
      if (sp) r.code = DECL_GO;
      else if (c == ChQmark) r.code = DECL_DONE;
      else if (c == 21'h65) begin r.code = DECL_GO; r.step = 6'd15; end
    end else if (s >= 6'd15 && s <= 6'd21) begin
      k = s - 6'd14;
      if (c == CpW'(encoding_char(k[2:0]))) begin r.code = DECL_GO; r.step = s + 6'd1; end
    end else if (s >= 6'd24 && s <= 6'd28) begin
      k = s - 6'd24;
      if (low == CpW'(utf8_char(k[2:0]))) begin r.code = DECL_GO; r.step = s + 6'd1; end
    end else if (s == 6'd30) begin
      if (sp) r.code = DECL_GO;
      else if (c == ChQmark) r.code = DECL_DONE;
    end
    return r;
  endfunction

  state_e         st_q, st_d;
  logic [DPW-1:0] depth_q, depth_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [FW-1:0]  cidx_q, cidx_d;
  logic [5:0]     dstep_q, dstep_d;
  logic           apos_q, apos_d;
  logic           err_q, err_d;
  logic [4:0]     tmin_q;
  logic           out_valid_q, out_valid_d;
  out_item_t      out_q, out_d;

  logic           fire;
  logic           have;
  logic [2:0]     kind;
  logic [CpW-1:0] ch;
  logic [1:0]     errc;
  logic [CpW-1:0] c;
  logic           sp;
  logic           name_we, start_we;
  logic [CpW-1:0] name_rdata;
  logic [FW-1:0]  start_rdata;
  logic [DPW-1:0] top_addr;
  decl_res_t      dr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign c          = in_data_i.code_point;
  assign sp         = is_white(c);
  assign top_addr   = depth_d - DPW'(1);

  xst_store #(
    .TAG_DEPTH (TAG_DEPTH),
    .NAME_STORE(NAME_STORE)
  ) u_store (
    .clk_i        (clk_i),
    .name_we_i    (name_we),
    .name_waddr_i (fill_q[NAW-1:0]),
    .name_wdata_i (c),
    .name_raddr_i (cidx_d[NAW-1:0]),
    .name_rdata_o (name_rdata),
    .start_we_i   (start_we),
    .start_waddr_i(depth_q[TAW-1:0]),
    .start_wdata_i(fill_q),
    .start_raddr_i(top_addr[TAW-1:0]),
    .start_rdata_o(start_rdata)
  );

  always_comb begin
    st_d     = st_q;
    depth_d  = depth_q;
    fill_d   = fill_q;
    cidx_d   = cidx_q;
    dstep_d  = dstep_q;
    apos_d   = apos_q;
    err_d    = err_q;
    have     = 1'b0;
    kind     = EV_ENAME;
    ch       = '0;
    errc     = ERR_NONE;
    name_we  = 1'b0;
    start_we = 1'b0;
    dr       = decl_take(c, (st_q == S_DECL) ? dstep_q : 6'd0, apos_q);
    if (fire && in_data_i.restart) begin
      st_d    = S_TEXT;
      depth_d = '0;
      fill_d  = '0;
      cidx_d  = '0;
      dstep_d = '0;
      apos_d  = 1'b0;
      err_d   = 1'b0;
    end else if (fire && !err_q) begin
      unique case (st_q)
        S_TEXT: begin
          if (c == ChLt) st_d = S_LT;
          else if (32'(depth_q) >= 32'(tmin_q)) begin kind = EV_TEXT; ch = c; have = 1'b1; end
        end
        S_LT: begin
          if (c == ChSlash) begin
            if (depth_q == '0) errc = ERR_SYNTAX;
            else begin cidx_d = start_rdata; st_d = S_END_FIRST; end
          end else if (c == ChQmark) begin
            st_d = S_PI_FIRST;
          end else if (!is_name_start(c)) begin
            errc = ERR_SYNTAX;
          end else if (depth_q >= DPW'(TAG_DEPTH) || fill_q >= FW'(NAME_STORE)) begin
            errc = ERR_CAPACITY;
          end else begin
            start_we = 1'b1;
            name_we  = 1'b1;
            depth_d  = depth_q + DPW'(1);
            fill_d   = fill_q + FW'(1);
            st_d     = S_ENAME;
            kind = EV_ENAME; ch = c; have = 1'b1;
          end
        end
        S_ENAME: begin
          if (is_name_part(c)) begin
            if (fill_q >= FW'(NAME_STORE)) errc = ERR_CAPACITY;
            else begin
              name_we = 1'b1;
              fill_d  = fill_q + FW'(1);
              kind = EV_ENAME; ch = c; have = 1'b1;
            end
          end else if (sp) st_d = S_BEFORE_ATTR;
          else if (c == ChSlash) st_d = S_EMPTY_CLOSE;
          else if (c == ChGt) begin st_d = S_TEXT; kind = EV_START_END; have = 1'b1; end
          else errc = ERR_SYNTAX;
        end
        S_BEFORE_ATTR: begin
          if (sp) st_d = S_BEFORE_ATTR;
          else if (c == ChSlash) st_d = S_EMPTY_CLOSE;
          else if (c == ChGt) begin st_d = S_TEXT; kind = EV_START_END; have = 1'b1; end
          else if (is_name_start(c)) begin
            st_d = S_ANAME; kind = EV_ANAME; ch = c; have = 1'b1;
          end else errc = ERR_SYNTAX;
        end
        S_ANAME: begin
          if (is_name_part(c)) begin kind = EV_ANAME; ch = c; have = 1'b1; end
          else if (sp) st_d = S_AFTER_ANAME;
          else if (c == ChEq) st_d = S_BEFORE_VAL;
          else errc = ERR_SYNTAX;
        end
        S_AFTER_ANAME: begin
          if (sp) st_d = S_AFTER_ANAME;
          else if (c == ChEq) st_d = S_BEFORE_VAL;
          else errc = ERR_SYNTAX;
        end
        S_BEFORE_VAL: begin
          if (sp) st_d = S_BEFORE_VAL;
          else if (c == ChApos || c == ChQuot) begin
            apos_d = (c == ChApos); st_d = S_VAL;
          end else errc = ERR_SYNTAX;
        end
        S_VAL: begin
          if (c == (apos_q ? ChApos : ChQuot)) begin
            st_d = S_AFTER_VAL; kind = EV_AVAL_END; have = 1'b1;
          end else begin kind = EV_AVAL; ch = c; have = 1'b1; end
        end
        S_AFTER_VAL: begin
          if (sp) st_d = S_BEFORE_ATTR;
          else if (c == ChSlash) st_d = S_EMPTY_CLOSE;
          else if (c == ChGt) begin st_d = S_TEXT; kind = EV_START_END; have = 1'b1; end
          else errc = ERR_SYNTAX;
        end
        S_EMPTY_CLOSE: begin
          if (c != ChGt) errc = ERR_SYNTAX;
          else begin
            depth_d = depth_q - DPW'(1);
            fill_d  = start_rdata;
            st_d    = S_TEXT;
            kind = EV_ELEM_END; have = 1'b1;
          end
        end
        S_END_FIRST, S_END_REST: begin
          if ((st_q == S_END_FIRST) ? is_name_start(c) : is_name_part(c)) begin
            if (cidx_q >= fill_q || name_rdata != c) errc = ERR_MISMATCH;
            else begin cidx_d = cidx_q + FW'(1); st_d = S_END_REST; end
          end else if (st_q == S_END_REST && (sp || c == ChGt)) begin
            if (cidx_q != fill_q) errc = ERR_MISMATCH;
            else if (sp) st_d = S_END_CLOSE;
            else begin
              depth_d = depth_q - DPW'(1);
              fill_d  = start_rdata;
              st_d    = S_TEXT;
              kind = EV_ELEM_END; have = 1'b1;
            end
          end else errc = ERR_SYNTAX;
        end
        S_END_CLOSE: begin
          if (sp) st_d = S_END_CLOSE;
          else if (c == ChGt) begin
            depth_d = depth_q - DPW'(1);
            fill_d  = start_rdata;
            st_d    = S_TEXT;
            kind = EV_ELEM_END; have = 1'b1;
          end else errc = ERR_SYNTAX;
        end
        S_PI_FIRST: begin
          if (!is_name_start(c)) errc = ERR_SYNTAX;
          else begin
            dstep_d = (c == CpW'(xml_char(2'd0))) ? 6'd1 : NotXml;
            st_d    = S_PI_NAME;
          end
        end
        S_PI_NAME: begin
          if (is_name_part(c)) begin
            if (dstep_q < 6'd3 && c == CpW'(xml_char(dstep_q[1:0]))) dstep_d = dstep_q + 6'd1;
            else dstep_d = NotXml;
          end else if (sp) st_d = S_PI_AFTER;
          else if (c == ChQmark) begin
            if (dstep_q == 6'd3) errc = ERR_SYNTAX;
            else st_d = S_PI_CLOSE;
          end else errc = ERR_SYNTAX;
        end
        S_PI_AFTER: begin
          if (sp) st_d = S_PI_AFTER;
          else if (dstep_q == 6'd3) begin
            dstep_d = dr.step;
            apos_d  = dr.apos;
            st_d    = S_DECL;
            if (dr.code == DECL_ERR) errc = ERR_SYNTAX;
            else if (dr.code == DECL_DONE) st_d = S_PI_CLOSE;
          end else st_d = (c == ChQmark) ? S_PI_CLOSE : S_PI_SKIP;
        end
        S_DECL: begin
          dstep_d = dr.step;
          apos_d  = dr.apos;
          if (dr.code == DECL_ERR) errc = ERR_SYNTAX;
          else if (dr.code == DECL_DONE) st_d = S_PI_CLOSE;
        end
        S_PI_SKIP: begin
          if (c == ChQmark) st_d = S_PI_CLOSE;
        end
        S_PI_CLOSE: begin
          if (c == ChGt) st_d = S_TEXT;
          else errc = ERR_SYNTAX;
        end
        default: errc = ERR_SYNTAX;
      endcase
      if (errc != ERR_NONE) begin
        err_d = 1'b1;
        kind  = EV_ENAME;
        ch    = '0;
        have  = 1'b1;
      end
    end
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (fire && have) begin
      out_valid_d      = 1'b1;
      out_d.event_kind = kind;
      out_d.event_char = ch;
      out_d.nest_depth = NestW'(depth_d);
      out_d.error_code = errc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_TEXT;
      depth_q     <= '0;
      fill_q      <= '0;
      cidx_q      <= '0;
      dstep_q     <= '0;
      apos_q      <= 1'b0;
      err_q       <= 1'b0;
      tmin_q      <= 5'd2;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      st_q        <= st_d;
      depth_q     <= depth_d;
      fill_q      <= fill_d;
      cidx_q      <= cidx_d;
      dstep_q     <= dstep_d;
      apos_q      <= apos_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (cfg_we_i) begin
        tmin_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_depth_bound, clk_i, rst_ni, depth_q <= DPW'(TAG_DEPTH))
  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= FW'(NAME_STORE))
  `ASSERT_IMPLIES(a_cmp_bound, clk_i, rst_ni, st_q == S_END_REST, cidx_q <= fill_q)
  `ASSERT_IMPLIES(a_err_silent, clk_i, rst_ni, fire && err_q && !in_data_i.restart, !have)

endmodule
